// File: rtl/core/gbm_pkg.sv
// gbm_pkg: shared constants, types and helpers of the Box-Muller sampler.
// No dependencies; used by gbm_radius, gbm_trig and the top level in rtl/core.
package gbm_pkg;

	localparam int unsigned LAT_RADIUS = 69;
	localparam int unsigned LAT_TRIG   = 18;
	localparam int unsigned LAT_ALIGN  = LAT_RADIUS - LAT_TRIG;

	localparam logic [25:0] TWO_LN2_Q25   = 26'd46516320;
	localparam logic [31:0] PI_OVER_4_Q32 = 32'd3373259426;

	localparam int unsigned SIN_DIV [0:3] = '{72, 42, 20, 6};
	localparam int unsigned COS_DIV [0:4] = '{90, 56, 30, 12, 2};

	localparam logic [1:0] REG_MEAN = 2'd0;
	localparam logic [1:0] REG_STD  = 2'd1;

	typedef struct packed {
		logic [2:0]  octant;
		logic [32:0] cos_mag;
		logic [31:0] sin_mag;
	} trig_res_t;

	function automatic logic [59:0] to_q60(input logic [31:0] w, input int unsigned ub);
		logic [59:0] m;
		m = (60'(1) << ub) - 60'(1);
		return (60'(w) & m) << (60 - ub);
	endfunction

endpackage

// File: rtl/core/gbm_in_if.sv
// gbm_in_if: input channel of the sampler, two raw uniform words per item.
// Standalone; valid/ready handshake.
interface gbm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] uniform_first;
	logic [31:0] uniform_second;

	modport source(output valid, uniform_first, uniform_second, input ready);
	modport sink(input valid, uniform_first, uniform_second, output ready);
endinterface

// File: rtl/core/gbm_out_if.sv
// gbm_out_if: output channel of the sampler, one Gaussian pair per item.
// Standalone; valid/ready handshake.
interface gbm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_cosine;
	logic signed [31:0] sample_sine;

	modport source(output valid, sample_cosine, sample_sine, input ready);
	modport sink(input valid, sample_cosine, sample_sine, output ready);
endinterface

// File: rtl/core/gbm_radius.sv
// gbm_radius: r = sqrt(-2 ln u1) in Q28; log by squaring, bit-serial square root.
// Depends on gbm_pkg. One stage per log bit and per root bit, LAT_RADIUS deep.
module gbm_radius
	import gbm_pkg::*;
#(
	parameter int unsigned UNIFORM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] word,
	output logic        out_valid,
	output logic [31:0] radius
);

	logic [59:0] f;
	logic [5:0]  p;

	logic [59:0] f_s1;
	logic [5:0]  p_s1;
	logic        vld_s1;

	logic [30:0] sq_x   [0:32];
	logic [31:0] sq_lg  [0:32];
	logic [5:0]  sq_ep  [0:32];
	logic        sq_vld [0:32];

	logic [37:0] nl_s3;
	logic        vld_s3;
	logic [57:0] plo_s4;
	logic [31:0] phi_s4;
	logic        vld_s4;
	logic [63:0] sum;

	logic [63:0] sr_v   [0:32];
	logic [63:0] sr_res [0:32];
	logic        sr_vld [0:32];

	always_comb begin
		f = to_q60(word, UNIFORM_BITS);
		p = '0;
		for (int i = 0; i < 60; i++) begin
			if (f[i]) p = 6'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			sq_vld[0] <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			sr_vld[0] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid && (f != '0);
			sq_vld[0] <= vld_s1;
			vld_s3    <= sq_vld[32];
			vld_s4    <= vld_s3;
			sr_vld[0] <= vld_s4;
		end
	end

	assign sum = {phi_s4, 32'b0} + 64'(plo_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1     <= f;
			p_s1     <= p;
			sq_x[0]  <= (p_s1 >= 6'd30) ? 31'(f_s1 >> (p_s1 - 6'd30))
			                             : 31'(f_s1 << (6'd30 - p_s1));
			sq_lg[0] <= '0;
			sq_ep[0] <= 6'd60 - p_s1;
			nl_s3    <= {sq_ep[32], 32'b0} - 38'(sq_lg[32]);
			plo_s4   <= 58'(nl_s3[31:0]) * 58'(TWO_LN2_Q25);
			phi_s4   <= 32'(nl_s3[37:32]) * 32'(TWO_LN2_Q25);
			sr_v[0]   <= {1'b0, sum[63:25], 24'b0};
			sr_res[0] <= '0;
		end
	end

	for (genvar k = 1; k <= 32; k++) begin : g_sq
		logic [61:0] prod;
		logic [31:0] y;
		assign prod = 62'(sq_x[k-1]) * 62'(sq_x[k-1]);
		assign y    = prod[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k] <= 1'b0;
			end else if (en) begin
				sq_vld[k] <= sq_vld[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ep[k] <= sq_ep[k-1];
				if (y[31]) begin
					sq_x[k]  <= y[31:1];
					sq_lg[k] <= sq_lg[k-1] | (32'(1) << (32 - k));
				end else begin
					sq_x[k]  <= y[30:0];
					sq_lg[k] <= sq_lg[k-1];
				end
			end
		end
	end

	for (genvar j = 1; j <= 32; j++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'(1) << (2 * (32 - j));
		logic [63:0] trial;
		assign trial = sr_res[j-1] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_vld[j] <= 1'b0;
			end else if (en) begin
				sr_vld[j] <= sr_vld[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (sr_v[j-1] >= trial) begin
					sr_v[j]   <= sr_v[j-1] - trial;
					sr_res[j] <= (sr_res[j-1] >> 1) + BIT;
				end else begin
					sr_v[j]   <= sr_v[j-1];
					sr_res[j] <= sr_res[j-1] >> 1;
				end
			end
		end
	end

	assign out_valid = sr_vld[32];
	assign radius    = sr_res[32][31:0];

endmodule

// File: rtl/core/gbm_trig.sv
// gbm_trig: octant split, theta in Q32 and Horner sine/cosine, LAT_TRIG deep.
// Depends on gbm_pkg. Divisions by constants use reciprocal multiply plus one fix-up.
module gbm_trig
	import gbm_pkg::*;
#(
	parameter int unsigned UNIFORM_BITS = 32
) (
	input  logic      clk,
	input  logic      en,
	input  logic [31:0] word,
	output trig_res_t res
);

	logic [59:0] a;
	logic [57:0] gm;
	logic [64:0] th_prod;
	logic [63:0] x2_prod;

	logic [2:0]  oct_s1;
	logic [32:0] gs_s1;
	logic [2:0]  oct_s2;
	logic [31:0] theta_s2;

	logic [31:0] x2_h    [0:15];
	logic [31:0] theta_h [0:15];
	logic [2:0]  oct_h   [0:15];

	logic [32:0] ct  [1:5];
	logic [31:0] cpr [0:4];
	logic [31:0] cpd [0:4];
	logic [31:0] cq  [0:4];
	logic [32:0] st  [1:4];
	logic [31:0] spr [0:3];
	logic [31:0] spd [0:3];
	logic [31:0] sq  [0:3];

	logic [31:0] sn_h13;
	logic [31:0] sn_h14;
	logic [31:0] sn_h15;

	always_comb begin
		a  = to_q60(word, UNIFORM_BITS);
		gm = a[57] ? (58'(1) << 57) - {1'b0, a[56:0]} : {1'b0, a[56:0]};
	end

	assign th_prod = 65'(gs_s1) * 65'(PI_OVER_4_Q32);
	assign x2_prod = 64'(theta_s2) * 64'(theta_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			oct_s1     <= a[59:57];
			gs_s1      <= gm[57:25];
			oct_s2     <= oct_s1;
			theta_s2   <= th_prod[63:32];
			x2_h[0]    <= x2_prod[63:32];
			theta_h[0] <= theta_s2;
			oct_h[0]   <= oct_s2;
			sn_h13     <= 32'((65'(theta_h[12]) * 65'(st[4])) >> 32);
			sn_h14     <= sn_h13;
			sn_h15     <= sn_h14;
		end
	end

	for (genvar h = 1; h <= 15; h++) begin : g_line
		always_ff @(posedge clk) begin
			if (en) begin
				x2_h[h]    <= x2_h[h-1];
				theta_h[h] <= theta_h[h-1];
				oct_h[h]   <= oct_h[h-1];
			end
		end
	end

	for (genvar n = 0; n < 5; n++) begin : g_cos
		localparam int unsigned K = COS_DIV[n];
		localparam int unsigned S = 31 + $clog2(K + 1);
		localparam logic [32:0] M = 33'((65'(1) << S) / 65'(K));
		logic [32:0] tin;
		logic [39:0] rem;
		logic [32:0] qc;

		if (n == 0) begin : g_first
			assign tin = 33'(1) << 32;
		end else begin : g_next
			assign tin = ct[n];
		end

		assign rem = 40'(cpd[n]) - 40'(cq[n]) * 40'(K);
		assign qc  = (rem >= 40'(K)) ? 33'(cq[n]) + 33'(1) : 33'(cq[n]);

		always_ff @(posedge clk) begin
			if (en) begin
				cpr[n]  <= 32'((65'(x2_h[3*n]) * 65'(tin)) >> 32);
				cpd[n]  <= cpr[n];
				cq[n]   <= 32'((65'(cpr[n]) * 65'(M)) >> S);
				ct[n+1] <= (33'(1) << 32) - qc;
			end
		end
	end

	for (genvar n = 0; n < 4; n++) begin : g_sin
		localparam int unsigned K = SIN_DIV[n];
		localparam int unsigned S = 31 + $clog2(K + 1);
		localparam logic [32:0] M = 33'((65'(1) << S) / 65'(K));
		logic [32:0] tin;
		logic [39:0] rem;
		logic [32:0] qc;

		if (n == 0) begin : g_first
			assign tin = 33'(1) << 32;
		end else begin : g_next
			assign tin = st[n];
		end

		assign rem = 40'(spd[n]) - 40'(sq[n]) * 40'(K);
		assign qc  = (rem >= 40'(K)) ? 33'(sq[n]) + 33'(1) : 33'(sq[n]);

		always_ff @(posedge clk) begin
			if (en) begin
				spr[n]  <= 32'((65'(x2_h[3*n]) * 65'(tin)) >> 32);
				spd[n]  <= spr[n];
				sq[n]   <= 32'((65'(spr[n]) * 65'(M)) >> S);
				st[n+1] <= (33'(1) << 32) - qc;
			end
		end
	end

	assign res.octant  = oct_h[15];
	assign res.cos_mag = ct[5];
	assign res.sin_mag = sn_h15;

endmodule

// File: rtl/core/gaussian_box_muller_sampler_unit.sv
// gaussian_box_muller_sampler_unit: top level of the Box-Muller Gaussian sampler.
// Depends on gbm_pkg, gbm_in_if, gbm_out_if, gbm_radius and gbm_trig.
//
// Usage:
//   uniforms (sink) takes one item per cycle: two raw uniform words. The first
//   word sets the radius, the second the angle as a fraction of a full turn.
//   An item whose first word is zero (after masking to UNIFORM_BITS) is dropped.
//   samples (source) gives one pair of signed Q16.16 samples per kept item:
//   mean + deviation * r * cos and mean + deviation * r * sin, saturated.
//   Configuration: write_enable/reg_index/write_data; index 0 is the mean,
//   index 1 the standard deviation. Write only while the block is idle.
// Timing:
//   An accepted item passes through the radius pipeline (32 log squaring stages,
//   32 root stages), then scaling registers s1 and s2 and the output register.
//   Throughput is one item per cycle; the angle path runs alongside the radius.
//   When samples.ready is low with a result waiting, the whole pipeline holds
//   and uniforms.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits, sets the mean to 0 and the deviation to 1.0.
module gaussian_box_muller_sampler_unit
	import gbm_pkg::*;
#(
	parameter int unsigned UNIFORM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	gbm_in_if.sink      uniforms,
	gbm_out_if.source   samples,
	input  logic        write_enable,
	input  logic [1:0]  reg_index,
	input  logic [31:0] write_data
);

	logic               en;
	logic signed [31:0] mean_q;
	logic [31:0]        std_q;

	logic [31:0] u2_dly [0:LAT_ALIGN-1];
	logic        rad_valid;
	logic [31:0] rad_r;
	trig_res_t   trig;

	logic [3:0]  oct_inc;
	logic        swap;
	logic [32:0] cmag;
	logic [32:0] smag;

	logic [31:0] zc_s1;
	logic [31:0] zs_s1;
	logic        negc_s1;
	logic        negs_s1;
	logic        vld_s1;

	logic [63:0] mc_prod;
	logic [63:0] ms_prod;
	logic [35:0] mc_s2;
	logic [35:0] ms_s2;
	logic        negc_s2;
	logic        negs_s2;
	logic        vld_s2;

	logic signed [37:0] vc;
	logic signed [37:0] vs;
	logic signed [31:0] satc;
	logic signed [31:0] sats;

	logic               out_vld_q;
	logic signed [31:0] cos_q;
	logic signed [31:0] sin_q;

	assign en             = !out_vld_q || samples.ready;
	assign uniforms.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			std_q  <= 32'd65536;
		end else if (write_enable) begin
			case (reg_index)
				REG_MEAN: mean_q <= write_data;
				REG_STD:  std_q  <= write_data;
				default: ;
			endcase
		end
	end

	gbm_radius #(.UNIFORM_BITS(UNIFORM_BITS)) u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (uniforms.valid),
		.word     (uniforms.uniform_first),
		.out_valid(rad_valid),
		.radius   (rad_r)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			u2_dly[0] <= uniforms.uniform_second;
		end
	end

	for (genvar i = 1; i < LAT_ALIGN; i++) begin : g_align
		always_ff @(posedge clk) begin
			if (en) begin
				u2_dly[i] <= u2_dly[i-1];
			end
		end
	end

	gbm_trig #(.UNIFORM_BITS(UNIFORM_BITS)) u_trig (
		.clk (clk),
		.en  (en),
		.word(u2_dly[LAT_ALIGN-1]),
		.res (trig)
	);

	always_comb begin
		oct_inc = 4'(trig.octant) + 4'd1;
		swap    = oct_inc[1];
		cmag    = swap ? 33'(trig.sin_mag) : trig.cos_mag;
		smag    = swap ? trig.cos_mag : 33'(trig.sin_mag);
	end

	assign mc_prod = 64'(zc_s1) * 64'(std_q) + (64'(1) << 27);
	assign ms_prod = 64'(zs_s1) * 64'(std_q) + (64'(1) << 27);

	always_comb begin
		vc = 38'(mean_q) + (negc_s2 ? -$signed(38'(mc_s2)) : $signed(38'(mc_s2)));
		vs = 38'(mean_q) + (negs_s2 ? -$signed(38'(ms_s2)) : $signed(38'(ms_s2)));
		if (vc > 38'sd2147483647) begin
			satc = 32'sh7fffffff;
		end else if (vc < -38'sd2147483648) begin
			satc = 32'sh80000000;
		end else begin
			satc = 32'(vc);
		end
		if (vs > 38'sd2147483647) begin
			sats = 32'sh7fffffff;
		end else if (vs < -38'sd2147483648) begin
			sats = 32'sh80000000;
		end else begin
			sats = 32'(vs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= rad_valid;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s1   <= 32'((65'(rad_r) * 65'(cmag)) >> 32);
			zs_s1   <= 32'((65'(rad_r) * 65'(smag)) >> 32);
			negc_s1 <= trig.octant[2] ^ trig.octant[1];
			negs_s1 <= trig.octant[2];
			mc_s2   <= mc_prod[63:28];
			ms_s2   <= ms_prod[63:28];
			negc_s2 <= negc_s1;
			negs_s2 <= negs_s1;
			cos_q   <= satc;
			sin_q   <= sats;
		end
	end

	assign samples.valid         = out_vld_q;
	assign samples.sample_cosine = cos_q;
	assign samples.sample_sine   = sin_q;

	a_hold_radius: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rad_valid) && $stable(rad_r))
		else $error("radius pipeline moved during stall");

	a_cos_above_mean: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s2 && !negc_s2 |=> samples.sample_cosine >= $past(mean_q))
		else $error("positive cosine sample below mean");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(samples.valid) |-> $past(vld_s2))
		else $error("output valid without an item in the last stage");

endmodule

// File: verif/gbm_tb_if.sv
`timescale 1ns / 1ps
// Testbench copies of the sampler channels are not needed; the RTL interfaces are used.
// This file holds the scoreboard class for the Box-Muller sampler; depends on gbm_pkg.
class gbm_scoreboard;
	logic [31:0] want_cos[$];
	logic [31:0] want_sin[$];
	int errors;
	int checked;
	logic [31:0] mean_reg;
	logic [31:0] std_reg;

	function new();
		errors = 0;
		checked = 0;
		mean_reg = 32'd0;
		std_reg = 32'd65536;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		if (idx == gbm_pkg::REG_MEAN) mean_reg = val;
		else if (idx == gbm_pkg::REG_STD) std_reg = val;
	endfunction

	function logic [63:0] neg_log2(logic [63:0] f);
		int p;
		logic [63:0] x, lg;
		p = 0;
		lg = 0;
		while (p < 59 && (f >> (p + 1)) != 0) p++;
		x = (p >= 30) ? (f >> (p - 30)) : (f << (30 - p));
		for (int i = 0; i < 32; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				lg[31 - i] = 1'b1;
			end
		end
		return (64'(60 - p) << 32) - lg;
	endfunction

	function logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function logic [31:0] scale_sample(logic [63:0] r, logic [63:0] trig, bit neg);
		logic [63:0] z, m;
		longint v;
		z = (r * trig) >> 32;
		m = (z * 64'(std_reg) + (64'd1 << 27)) >> 28;
		v = neg ? -longint'(m) : longint'(m);
		v = v + longint'($signed(mean_reg));
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function void note_input(logic [31:0] u1, logic [31:0] u2);
		logic [63:0] f1, a, lval, r, g, theta, x2, t, sn, cs, one;
		logic [2:0] oct;
		bit swap;
		one = 64'd1 << 32;
		f1 = 64'(u1) << 28;
		a = 64'(u2) << 28;
		if (f1 == 0) return;
		lval = (neg_log2(f1) * 64'(gbm_pkg::TWO_LN2_Q25)) >> 25;
		r = root64(lval << 24);
		oct = a[59:57];
		g = a & ((64'd1 << 57) - 1);
		if (oct[0]) g = (64'd1 << 57) - g;
		theta = ((g >> 25) * 64'(gbm_pkg::PI_OVER_4_Q32)) >> 32;
		x2 = (theta * theta) >> 32;
		t = one;
		foreach (gbm_pkg::SIN_DIV[k]) t = one - ((x2 * t) >> 32) / gbm_pkg::SIN_DIV[k];
		sn = (theta * t) >> 32;
		t = one;
		foreach (gbm_pkg::COS_DIV[k]) t = one - ((x2 * t) >> 32) / gbm_pkg::COS_DIV[k];
		cs = t;
		swap = ((oct + 3'd1) >> 1) & 1;
		want_cos.push_back(scale_sample(r, swap ? sn : cs, oct >= 2 && oct <= 5));
		want_sin.push_back(scale_sample(r, swap ? cs : sn, oct >= 4));
	endfunction

	function void check_result(logic [31:0] c, logic [31:0] s);
		logic [31:0] ec, es;
		checked++;
		if (want_cos.size() == 0) begin
			report("result with nothing expected", 0, c);
			return;
		end
		ec = want_cos.pop_front();
		es = want_sin.pop_front();
		if (c !== ec) report("sample_cosine", ec, c);
		if (s !== es) report("sample_sine", es, s);
	endfunction

	function void report(string what, logic [31:0] exp_v, logic [31:0] got);
		errors++;
		if (errors <= 40) $display("mismatch %s: expected %h got %h", what, exp_v, got);
	endfunction
endclass

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the Box-Muller sampler testbench: drives uniform pairs and register writes,
// checks every sample pair against the scoreboard. Depends on gbm_pkg, the RTL and gbm_tb_if.sv.
module testbench;
	import gbm_pkg::*;

	logic clk;
	logic arst_n;
	logic write_enable;
	logic [1:0] reg_index;
	logic [31:0] write_data;
	int cycles;
	int sent;
	bit feeding;

	gbm_in_if uniforms();
	gbm_out_if samples();
	gbm_scoreboard board;

	gaussian_box_muller_sampler_unit u_top (
		.clk(clk), .arst_n(arst_n), .uniforms(uniforms.sink), .samples(samples.source),
		.write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		uniforms.valid = 0;
		uniforms.uniform_first = 0;
		uniforms.uniform_second = 0;
		samples.ready = 0;
		write_enable = 0;
		reg_index = 0;
		write_data = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, with calm stretches
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = (feeding && (sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 10);
			if (w > 0) begin
				samples.ready <= 0;
				repeat (w) @(posedge clk);
			end
			samples.ready <= 1;
			@(posedge clk);
			while (!samples.valid) @(posedge clk);
			board.check_result(samples.sample_cosine, samples.sample_sine);
		end
	end

	task automatic send(logic [31:0] u1, logic [31:0] u2, bit gaps);
		int w;
		w = (gaps && (sent / 150) % 3 != 1) ? $urandom_range(0, 10) : 0;
		if (w > 0) begin
			uniforms.valid <= 0;
			repeat (w) @(posedge clk);
		end
		uniforms.valid <= 1;
		uniforms.uniform_first <= u1;
		uniforms.uniform_second <= u2;
		@(posedge clk);
		while (!uniforms.ready) @(posedge clk);
		board.note_input(u1, u2);
		sent++;
	endtask

	task automatic drain();
		uniforms.valid <= 0;
		@(posedge clk);
		while (board.want_cos.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		write_enable <= 1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
		write_enable <= 0;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_first();
		case ($urandom_range(0, 5))
			0: return 32'd1 << $urandom_range(0, 31);
			1: return $urandom_range(0, 15);
			2: return 32'hFFFFFFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] means[6];
		logic [31:0] stds[6];
		board = new();
		sent = 0;
		feeding = 1;
		means = '{32'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h00050000, $urandom};
		stds = '{32'd65536, 32'hFFFFFFFF, 32'd0, 32'd1, 32'h00008000, $urandom};
		@(posedge arst_n);
		@(posedge clk);
		// directed: extremes of both words, each octant boundary, a zero first word
		send(32'd1, 32'd0, 0);
		send(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send(32'd0, 32'h12345678, 0);
		send(32'h80000000, 32'h80000000, 0);
		for (int k = 0; k < 8; k++) send(32'h40000000, 32'(k) << 29, 0);
		for (int k = 0; k < 8; k++) send(32'h00000100, (32'(k) << 29) + 32'h10000000, 0);
		drain();
		write_reg(2'd2, 32'hDEADBEEF);
		write_reg(2'd3, 32'h12345678);
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_MEAN, means[ph]);
			write_reg(REG_STD, stds[ph]);
			for (int n = 0; n < 320; n++) send(rand_first(), $urandom, 1);
			drain();
		end
		send(32'h00000001, 32'h20000000, 1);
		feeding = 0;
		drain();
		$display("sent %0d uniform pairs over 6 register settings, checked %0d sample pairs",
			sent, board.checked);
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
